/* rtl/jsm_pkg.sv */
// Package: shared types and constants of the jump segmenter with mean.
`timescale 1ns / 1ps
package jsm_pkg;

	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = 4;

	localparam logic [LEN_W-1:0] MAX_SEG_LEN   = 16'hFFFF;
	localparam logic [THR_W-1:0] THR_RESET     = 16'd128;

	typedef struct packed {
		logic load_item;
		logic start_div;
		logic div_final;
		logic add_item;
		logic load_out;
	} jsm_cmd_t;

	typedef struct packed {
		logic jump_before;
		logic jump_after;
		logic item_last;
		logic div_busy;
		logic out_free;
	} jsm_status_t;

endpackage

/* rtl/jsm_ctrl.sv */
// Controller: sequences one beat through close-before, accumulate and close-after.
`timescale 1ns / 1ps
module jsm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jsm_pkg::jsm_status_t status,
	output jsm_pkg::jsm_cmd_t    cmd
);
	import jsm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_OUT1 = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_POST = 3'd5;
	localparam logic [2:0] S_DIV2 = 3'd6;
	localparam logic [2:0] S_OUT2 = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (status.jump_before) begin
					cmd.start_div = 1'b1;
					cmd.div_final = 1'b0;
					state_d = S_DIV1;
				end else begin
					state_d = S_ADD;
				end
			end
			S_DIV1: begin
				if (!status.div_busy) state_d = S_OUT1;
			end
			S_OUT1: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_item = 1'b1;
				state_d = S_POST;
			end
			S_POST: begin
				if (status.jump_after || status.item_last) begin
					cmd.start_div = 1'b1;
					cmd.div_final = status.item_last;
					state_d = S_DIV2;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV2: begin
				if (!status.div_busy) state_d = S_OUT2;
			end
			S_OUT2: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_out_when_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !status.div_busy)
		else $error("result loaded while divider busy");

	a_start_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |-> !status.div_busy)
		else $error("divider restarted while busy");

	a_close_after_follows_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST) |-> $past(cmd.add_item))
		else $error("close-after check without accumulate");

endmodule

/* rtl/jsm_dp.sv */
// Datapath: sequence state, segment accumulator, serial divider and result register.
`timescale 1ns / 1ps
module jsm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [jsm_pkg::THR_W-1:0]      cfg_data,
	input  logic signed [jsm_pkg::LEVEL_W-1:0] level,
	input  logic [jsm_pkg::VALUE_W-1:0]    sample_value,
	input  logic                           stream_end,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [jsm_pkg::LEN_W-1:0]      segment_length,
	output logic [jsm_pkg::VALUE_W-1:0]    segment_mean,
	output logic                           final_segment,
	input  jsm_pkg::jsm_cmd_t              cmd,
	output jsm_pkg::jsm_status_t           status
);
	import jsm_pkg::*;

	logic [THR_W-1:0]          thr_q;
	logic signed [LEVEL_W-1:0] prev_q;
	logic [SUM_W-1:0]          sum_q;
	logic [LEN_W-1:0]          len_q;
	logic                      seen_q;
	logic                      cap_q;

	logic signed [LEVEL_W-1:0] lv_q;
	logic [VALUE_W-1:0]        val_q;
	logic                      last_q;
	logic                      before_q;
	logic                      after_q;

	logic signed [LEVEL_W:0]   diff;
	logic [LEVEL_W:0]          adiff;
	logic                      jump;

	logic                      busy_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic [LEN_W-1:0]          rem_q;
	logic [VALUE_W-1:0]        quo_q;
	logic [LEN_W-1:0]          dvs_q;
	logic                      zlen_q;
	logic                      fin_q;
	logic [LEN_W:0]            trial;
	logic                      qbit;

	logic                      out_valid_q;
	logic [LEN_W-1:0]          out_len_q;
	logic [VALUE_W-1:0]        out_mean_q;
	logic                      out_fin_q;

	// jump test on the incoming beat against the stored sequence state
	assign diff  = {prev_q[LEVEL_W-1], prev_q} - {level[LEVEL_W-1], level};
	assign adiff = diff[LEVEL_W] ? (LEVEL_W+1)'(0) - diff : diff;
	assign jump  = (prev_q != '0) && (level != '0) && (adiff > {1'b0, thr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			lv_q     <= level;
			val_q    <= sample_value;
			last_q   <= stream_end;
			before_q <= jump && !seen_q;
			after_q  <= jump && seen_q && !cap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
			len_q  <= '0;
			seen_q <= 1'b0;
			cap_q  <= 1'b0;
		end else begin
			if (cmd.start_div) begin
				sum_q <= '0;
				len_q <= '0;
			end else if (cmd.add_item && (len_q < MAX_SEG_LEN)) begin
				sum_q <= sum_q + SUM_W'(val_q);
				len_q <= len_q + 1'b1;
			end
			if (cmd.add_item) begin
				if (last_q) begin
					prev_q <= '0;
					seen_q <= 1'b0;
					cap_q  <= 1'b0;
				end else begin
					prev_q <= lv_q;
					seen_q <= seen_q | before_q | after_q;
					cap_q  <= after_q;
				end
			end
		end
	end

	// restoring divider, one quotient bit per cycle; sum < len * 2^16 keeps it to 16 steps
	assign trial = {rem_q, quo_q[VALUE_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start_div) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q  <= sum_q[SUM_W-1:VALUE_W];
			quo_q  <= sum_q[VALUE_W-1:0];
			dvs_q  <= len_q;
			zlen_q <= (len_q == '0);
			fin_q  <= cmd.div_final;
		end else if (busy_q) begin
			rem_q <= qbit ? LEN_W'(trial - {1'b0, dvs_q}) : trial[LEN_W-1:0];
			quo_q <= {quo_q[VALUE_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_len_q  <= dvs_q;
			out_mean_q <= zlen_q ? '0 : quo_q;
			out_fin_q  <= fin_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign segment_length = out_len_q;
	assign segment_mean   = out_mean_q;
	assign final_segment  = out_fin_q;

	assign status.jump_before = before_q;
	assign status.jump_after  = after_q;
	assign status.item_last   = last_q;
	assign status.div_busy    = busy_q;
	assign status.out_free    = !out_valid_q || out_ready;

	a_len_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_item && !cmd.start_div && (len_q == MAX_SEG_LEN)) |=> (len_q == MAX_SEG_LEN))
		else $error("segment length wrapped");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !zlen_q) |-> (rem_q < dvs_q))
		else $error("divider remainder out of range");

	a_no_load_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && out_valid_q) |-> out_ready)
		else $error("result register overwritten");

endmodule

/* rtl/jump_segmenter_with_mean_core.sv */
// Top level: jump segmenter with per-segment truncated mean.
//
// Input channel (in_valid/in_ready) takes one beat of level (signed Q8.8),
// sample_value (unsigned Q4.12) and stream_end. Each beat yields zero, one or
// two result beats on the output channel (out_valid/out_ready): segment_length,
// segment_mean (Q4.12, truncated) and final_segment.
// Configuration channel (cfg_valid/cfg_ready) writes jump_threshold; it is
// always ready and must only be used while the block is idle.
// One input beat is taken at a time. Each close runs the 16-step bit-serial
// divider and then one result load before the next input beat is accepted.
// A result waits in the output register while the next beat is accepted; a
// receiver stall holds the controller only when a second result is ready.
// Reset clears the sequence state and restores the threshold to 0.5 (128).
`timescale 1ns / 1ps
module jump_segmenter_with_mean_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jsm_pkg::THR_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [jsm_pkg::LEVEL_W-1:0] level,
	input  logic [jsm_pkg::VALUE_W-1:0]        sample_value,
	input  logic                               stream_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [jsm_pkg::LEN_W-1:0]          segment_length,
	output logic [jsm_pkg::VALUE_W-1:0]        segment_mean,
	output logic                               final_segment
);
	import jsm_pkg::*;

	jsm_cmd_t    cmd;
	jsm_status_t status;

	assign cfg_ready = 1'b1;

	jsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	jsm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.level          (level),
		.sample_value   (sample_value),
		.stream_end     (stream_end),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.segment_length (segment_length),
		.segment_mean   (segment_mean),
		.final_segment  (final_segment),
		.cmd            (cmd),
		.status         (status)
	);

endmodule
